FILE: hw/rtl/stip_pkg.sv
`timescale 1ns / 1ps
// stip_pkg: types, constants and the digit decoder of the string-to-integer parser
// used by stip_step and string_to_integer_parser_unit; no dependencies
package stip_pkg;

    localparam logic [63:0] LLONG_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LLONG_MIN_MAG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ULLONG_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] LOW_BIAS  = 8'h57;   // 'a' - 10
    localparam logic [7:0] UP_BIAS   = 8'h37;   // 'A' - 10

    localparam logic [5:0] NO_DIGIT  = 6'd63;
    localparam logic [5:0] BASE_MAX  = 6'd36;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_HEX  = 6'd16;
    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_ONE  = 6'd1;
    localparam logic [5:0] BASE_MIN  = 6'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_SIGN,
        PH_ZERO,
        PH_XPREF,
        PH_DIGITS
    } stip_phase_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_BUMP,
        ACT_DIGIT,
        ACT_FINISH,
        ACT_EMIT_PREFIX
    } stip_action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_DIGIT = 2'd1,
        ST_OVERFLOW = 2'd2
    } stip_status_t;

    typedef enum logic [0:0] {
        CFG_NUMBER_BASE   = 1'b0,
        CFG_SIGNED_RESULT = 1'b1
    } stip_cfg_idx_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } stip_char_t;

    typedef struct packed {
        logic [63:0]  value;
        stip_status_t status;
        logic [15:0]  end_offset;
    } stip_result_t;

    typedef struct packed {
        stip_phase_t phase;
        logic [63:0] acc;
        logic        negative;
        logic [5:0]  base;
        logic        ovf;
        logic        seen;
    } stip_state_t;

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd63;
            if (c >= CH_ZERO && c <= CH_NINE)
                d = c - CH_ZERO;
            else if (c >= CH_LOW_A && c <= CH_LOW_Z)
                d = c - LOW_BIAS;
            else if (c >= CH_UP_A && c <= CH_UP_Z)
                d = c - UP_BIAS;
            digit_of = (d == 8'd63) ? NO_DIGIT : d[5:0];
        end
    endfunction

endpackage

FILE: hw/rtl/string_to_integer_parser_unit.sv
`timescale 1ns / 1ps
// string_to_integer_parser_unit: streaming strtoll/strtoull style text-to-integer parser
// depends on stip_pkg and stip_step
//
// Characters arrive one per request on char_valid/char_stall/char_data; first marks
// the start of a new string. Leading white space, an optional sign and an optional
// 0x prefix are taken, then digits in the configured base. The first character not
// accepted ends the parse and produces one result on res_valid/res_stall/res_data:
// the value, a status (ok, no digits, saturated overflow) and the characters used.
// Configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data (cfg_ready is
// always high); the user must write it only while the unit is idle, which it does not enforce.
// Each character is held in the input register, then the parse step and the result
// register take it, and res_valid comes from the result register. One character is
// taken every cycle while res_stall does not hold a pending result; the parse state
// loop (multiply-add by the base, cutoff compare) is combinational around its register.
// Reset: base 10, signed mode, parser idle, no result pending.
// While res_stall holds a pending result, the parse step waits on its next character
// and char_stall rises once the input register is full.
module string_to_integer_parser_unit #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_stall,
    input  stip_pkg::stip_char_t    char_data,
    output logic                    res_valid,
    input  logic                    res_stall,
    output stip_pkg::stip_result_t  res_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  stip_pkg::stip_cfg_idx_t cfg_index,
    input  logic [5:0]              cfg_data
);
    import stip_pkg::*;

    logic [5:0]             base_reg;
    logic                   signed_reg;

    logic                   in_valid_reg;
    stip_char_t             in_reg;

    stip_state_t            state_reg;
    stip_state_t            state_next;
    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;

    logic                   out_valid_reg;
    stip_result_t           out_reg;

    logic                   step_result_valid;
    stip_result_t           step_result;
    logic                   out_free;
    logic                   step_go;

    stip_step #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_step (
        .state        (state_reg),
        .count        (count_reg),
        .item         (in_reg),
        .number_base  (base_reg),
        .signed_result(signed_reg),
        .state_next   (state_next),
        .count_next   (count_next),
        .result_valid (step_result_valid),
        .result       (step_result)
    );

    assign out_free   = !out_valid_reg || !res_stall;
    assign step_go    = in_valid_reg && out_free;
    assign char_stall = in_valid_reg && !out_free;
    assign res_valid  = out_valid_reg;
    assign res_data   = out_reg;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_DEC;
            signed_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NUMBER_BASE:   base_reg   <= cfg_data;
                CFG_SIGNED_RESULT: signed_reg <= cfg_data[0];
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!char_stall)
            in_valid_reg <= char_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid)
            in_reg <= char_data;
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase    <= PH_IDLE;
            state_reg.acc      <= '0;
            state_reg.negative <= 1'b0;
            state_reg.base     <= BASE_DEC;
            state_reg.ovf      <= 1'b0;
            state_reg.seen     <= 1'b0;
            count_reg          <= '0;
        end
        else if (step_go)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_go && step_result_valid)
            out_valid_reg <= 1'b1;
        else if (!res_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_go && step_result_valid)
            out_reg <= step_result;
    end

endmodule

FILE: hw/rtl/stip_step.sv
`timescale 1ns / 1ps
// stip_step: one-character parse step, next state and optional result
// depends on stip_pkg
module stip_step #(
    parameter int OFFSET_BITS = 16
) (
    input  stip_pkg::stip_state_t  state,
    input  logic [OFFSET_BITS-1:0] count,
    input  stip_pkg::stip_char_t   item,
    input  logic [5:0]             number_base,
    input  logic                   signed_result,
    output stip_pkg::stip_state_t  state_next,
    output logic [OFFSET_BITS-1:0] count_next,
    output logic                   result_valid,
    output stip_pkg::stip_result_t result
);
    import stip_pkg::*;

    stip_state_t            e_st;
    logic [OFFSET_BITS-1:0] e_count;
    logic [OFFSET_BITS-1:0] count_bumped;
    logic [5:0]             chr_digit;
    logic                   is_space;

    stip_action_t act;
    stip_phase_t  ph;
    logic [5:0]   b;
    logic         ng;
    logic [5:0]   dig;

    logic [63:0]  lim;
    logic [70:0]  sum;
    logic         fits;

    // restart on first character
    always_comb
    begin
        e_st    = state;
        e_count = count;
        if (item.first)
        begin
            e_st.phase    = PH_SPACE;
            e_st.acc      = '0;
            e_st.negative = 1'b0;
            e_st.base     = number_base;
            e_st.ovf      = 1'b0;
            e_st.seen     = 1'b0;
            e_count       = '0;
        end
    end

    assign chr_digit    = digit_of(item.ch);
    assign is_space     = (item.ch == CH_SPACE) || (item.ch >= CH_TAB && item.ch <= CH_CR);
    assign count_bumped = (e_count == '1) ? e_count : e_count + 1'b1;

    // phase walk: decides the action, next phase and resolved base
    always_comb
    begin
        logic done;
        done = 1'b0;
        act  = ACT_NONE;
        ph   = e_st.phase;
        b    = e_st.base;
        ng   = e_st.negative;
        dig  = '0;
        if (ph == PH_IDLE)
            done = 1'b1;
        else if (b == BASE_ONE || b > BASE_MAX)
        begin
            act  = ACT_FINISH;
            done = 1'b1;
        end
        if (!done && ph == PH_SPACE)
        begin
            if (is_space)
            begin
                act  = ACT_BUMP;
                done = 1'b1;
            end
            else
            begin
                ph = PH_SIGN;
                if (item.ch == CH_PLUS || item.ch == CH_MINUS)
                begin
                    ng   = (item.ch == CH_MINUS);
                    act  = ACT_BUMP;
                    done = 1'b1;
                end
            end
        end
        if (!done && ph == PH_SIGN)
        begin
            if ((b == BASE_AUTO || b == BASE_HEX) && item.ch == CH_ZERO)
            begin
                act  = ACT_DIGIT;
                ph   = PH_ZERO;
                done = 1'b1;
            end
            else
            begin
                if (b == BASE_AUTO)
                    b = BASE_DEC;
                ph = PH_DIGITS;
            end
        end
        if (!done && ph == PH_ZERO)
        begin
            if (item.ch == CH_LOW_X || item.ch == CH_UP_X)
            begin
                act  = ACT_BUMP;
                b    = BASE_HEX;
                ph   = PH_XPREF;
                done = 1'b1;
            end
            else
            begin
                if (b == BASE_AUTO)
                    b = BASE_OCT;
                ph = PH_DIGITS;
            end
        end
        if (!done && ph == PH_XPREF)
        begin
            if (chr_digit < BASE_HEX)
            begin
                act = ACT_DIGIT;
                dig = chr_digit;
                ph  = PH_DIGITS;
            end
            else
                act = ACT_EMIT_PREFIX;
            done = 1'b1;
        end
        if (!done)
        begin
            if (b >= BASE_MIN && chr_digit < b)
            begin
                act = ACT_DIGIT;
                dig = chr_digit;
            end
            else
                act = ACT_FINISH;
        end
        if (act == ACT_FINISH || act == ACT_EMIT_PREFIX)
            ph = PH_IDLE;
    end

    assign lim  = !signed_result ? ULLONG_MAX : (ng ? LLONG_MIN_MAG : LLONG_MAX);
    // acc * base + digit never wraps at 71 bits, so the cutoff test is a plain compare
    assign sum  = (71'(e_st.acc) * 71'(b)) + 71'(dig);
    assign fits = (sum <= 71'(lim));

    // datapath and result
    always_comb
    begin
        state_next          = e_st;
        state_next.phase    = ph;
        state_next.base     = b;
        state_next.negative = ng;
        count_next          = e_count;
        result_valid        = 1'b0;
        result.value        = '0;
        result.status       = ST_OK;
        result.end_offset   = 16'(e_count);
        unique case (act)
            ACT_NONE:
            begin
            end
            ACT_BUMP:
                count_next = count_bumped;
            ACT_DIGIT:
            begin
                state_next.seen = 1'b1;
                count_next      = count_bumped;
                if (!e_st.ovf && b >= BASE_MIN)
                begin
                    if (fits)
                        state_next.acc = sum[63:0];
                    else
                        state_next.ovf = 1'b1;
                end
            end
            ACT_FINISH:
            begin
                result_valid = 1'b1;
                if (!e_st.seen)
                begin
                    result.status     = ST_NO_DIGIT;
                    result.end_offset = '0;
                end
                else if (e_st.ovf || e_st.acc > lim)
                begin
                    result.status = ST_OVERFLOW;
                    result.value  = signed_result ? (ng ? LLONG_MIN_MAG : LLONG_MAX)
                                                  : ULLONG_MAX;
                end
                else
                    result.value = ng ? (64'd0 - e_st.acc) : e_st.acc;
            end
            ACT_EMIT_PREFIX:
            begin
                // bare 0x prefix: stop just past the zero
                result_valid      = 1'b1;
                result.end_offset = 16'((e_count != '0) ? e_count - 1'b1 : e_count);
            end
            default:
            begin
            end
        endcase
    end

endmodule
